// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

	localparam logic [7:0] HEADER_BYTE    = 8'hFC;
	localparam logic [7:0] ACK_COMMAND    = 8'h00;
	localparam int         FRAME_OVERHEAD = 5;
	// first payload byte sits after header, two length bytes and command
	localparam int         PAYLOAD_OFFSET = 4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_HDR  = 2'd1;
	localparam logic [1:0] ST_BAD_SUM  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// what one received byte causes
	typedef struct packed {
		logic       fire;     // at least one result follows
		logic       run;      // payload run read back from the buffer
		logic [1:0] status;
		logic [7:0] command;
		logic [5:0] plen;
	} ev_t;

endpackage

// ===== rtl/sfr_ram.sv =====
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/sfr_parser.sv =====
module sfr_parser import sfr_pkg::*; #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            acc,
	input  logic [7:0]                      rx_byte,
	output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
	output ev_t                             ev
);

	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int AW = $clog2(BUFFER_BYTES);

	logic [CW-1:0] cnt_q;
	logic [15:0]   len_q;
	logic [7:0]    sum_q;
	logic [7:0]    cmd_q;
	logic          hdr_ok_q;

	logic [CW-1:0] cnt_new;
	logic          complete;
	logic          overflow;

	// count stays below the buffer size between items
	assign cnt_new  = cnt_q + CW'(1);
	assign wr_addr  = cnt_q[AW-1:0];
	assign complete = (cnt_new >= CW'(FRAME_OVERHEAD)) &&
	                  (17'(cnt_new) == 17'(len_q) + 17'(FRAME_OVERHEAD));
	assign overflow = !complete && (cnt_new == CW'(BUFFER_BYTES));

	always_comb begin
		ev = '0;
		if (complete) begin
			ev.fire = 1'b1;
			priority if (!hdr_ok_q) begin
				ev.status = ST_BAD_HDR;
			end else if (sum_q != rx_byte) begin
				ev.status = ST_BAD_SUM;
			end else begin
				ev.status  = ST_OK;
				ev.fire    = (cmd_q != ACK_COMMAND);
				ev.run     = (len_q != 16'd0);
				ev.command = cmd_q;
				ev.plen    = len_q[5:0];
			end
		end else if (overflow) begin
			ev.fire   = 1'b1;
			ev.status = ST_OVERFLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			cmd_q    <= '0;
			hdr_ok_q <= 1'b0;
		end else if (acc) begin
			if (complete || overflow) begin
				cnt_q <= '0;
				len_q <= '0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_new;
				sum_q <= sum_q + rx_byte;
				if (cnt_q == CW'(0)) hdr_ok_q <= (rx_byte == HEADER_BYTE);
				if (cnt_q == CW'(1)) len_q[15:8] <= rx_byte;
				if (cnt_q == CW'(2)) len_q[7:0] <= rx_byte;
				if (cnt_q == CW'(3)) cmd_q <= rx_byte;
			end
		end
	end

endmodule

// ===== rtl/serial_frame_receiver_top.sv =====
// Bytes that cause no result are taken back to back while idle; a byte that
// causes a single result holds off input until that result is loaded into
// the output register. A good frame with payload holds off input while its
// payload is read back from the frame buffer RAM: each byte is read, then
// loaded into the output register; loads wait while the output stalls.
// Reset clears all control state; buffer contents are never cleared.
module serial_frame_receiver_top import sfr_pkg::*; #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] command,
	output logic [5:0] payload_len,
	output logic       has_payload,
	output logic [5:0] payload_index,
	output logic [7:0] payload_byte,
	output logic       last
);

	localparam int AW = $clog2(BUFFER_BYTES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ONE  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_LD   = 2'd3;

	logic [1:0]    state_q;
	ev_t           ev;
	ev_t           ev_q;
	logic [5:0]    idx_q;
	logic [AW-1:0] wr_addr;
	logic [7:0]    rd_data;
	logic          in_acc;
	logic          out_free;
	logic          out_load;
	logic          run_last;

	logic       out_valid_q;
	logic [1:0] status_q;
	logic [7:0] command_q;
	logic [5:0] payload_len_q;
	logic       has_payload_q;
	logic [5:0] payload_index_q;
	logic [7:0] payload_byte_q;
	logic       last_q;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && ((state_q == S_ONE) || (state_q == S_LD));
	assign run_last = ({1'b0, idx_q} + 7'd1) == {1'b0, ev_q.plen};

	sfr_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (in_acc),
		.rx_byte (rx_byte),
		.wr_addr (wr_addr),
		.ev      (ev)
	);

	sfr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_buf (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_en   (state_q == S_RD),
		.rd_addr (AW'(idx_q) + AW'(PAYLOAD_OFFSET)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ev_q    <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && ev.fire) begin
						ev_q    <= ev;
						idx_q   <= '0;
						state_q <= ev.run ? S_RD : S_ONE;
					end
				end
				S_ONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					if (out_free) begin
						if (run_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 6'd1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_ONE) begin
				status_q        <= ev_q.status;
				command_q       <= ev_q.command;
				payload_len_q   <= ev_q.plen;
				has_payload_q   <= 1'b0;
				payload_index_q <= '0;
				payload_byte_q  <= '0;
				last_q          <= 1'b1;
			end else if (state_q == S_LD) begin
				status_q        <= ST_OK;
				command_q       <= ev_q.command;
				payload_len_q   <= ev_q.plen;
				has_payload_q   <= 1'b1;
				payload_index_q <= idx_q;
				payload_byte_q  <= rd_data;
				last_q          <= run_last;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign command       = command_q;
	assign payload_len   = payload_len_q;
	assign has_payload   = has_payload_q;
	assign payload_index = payload_index_q;
	assign payload_byte  = payload_byte_q;
	assign last          = last_q;

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_payload |-> status == ST_OK)
		else $error("payload result with error status");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && command == 8'd0 && !has_payload)
		else $error("error result not a lone final result");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_payload |-> payload_index < payload_len)
		else $error("payload index beyond payload length");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |=> in_stall && state_q == S_LD)
		else $error("buffer read not followed by load");

endmodule

// ===== sim/serial_frame_receiver_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, tracks the frame state per received byte and
// compares each result item against the oldest one still owed.
module serial_frame_receiver_checker import sfr_pkg::*; #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] status,
	input  logic [7:0] command,
	input  logic [5:0] payload_len,
	input  logic       has_payload,
	input  logic [5:0] payload_index,
	input  logic [7:0] payload_byte,
	input  logic       last,
	output int         mismatches,
	output int         pending
);

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] command;
		logic [5:0] plen;
		logic       has_p;
		logic [5:0] idx;
		logic [7:0] data;
		logic       last;
	} frame_result_t;

	frame_result_t results_due[$];
	logic [7:0]    frame_bytes [BUFFER_BYTES];
	int            byte_count  = 0;
	int            frame_len   = 0;
	logic [7:0]    running_sum = 8'h00;

	task automatic owe_result(input logic [1:0] st, input logic [7:0] cmd, input int plen,
			input logic has_p, input int idx, input logic [7:0] data, input logic lst);
		frame_result_t r;
		r.status  = st;
		r.command = cmd;
		r.plen    = plen[5:0];
		r.has_p   = has_p;
		r.idx     = idx[5:0];
		r.data    = data;
		r.last    = lst;
		results_due.push_back(r);
	endtask

	task automatic restart_frame;
		byte_count  = 0;
		frame_len   = 0;
		running_sum = 8'h00;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] sum_prior;
		logic [7:0] cmd;
		int         i;
		sum_prior = running_sum;
		if (byte_count >= BUFFER_BYTES)
			byte_count = 0;
		frame_bytes[byte_count] = b;
		byte_count  = byte_count + 1;
		running_sum = running_sum + b;
		if (byte_count == 4)
			frame_len = int'({frame_bytes[1], frame_bytes[2]});
		if (byte_count >= FRAME_OVERHEAD && byte_count == FRAME_OVERHEAD + frame_len) begin
			cmd = frame_bytes[3];
			// header is judged before the checksum
			if (frame_bytes[0] != HEADER_BYTE)
				owe_result(ST_BAD_HDR, 8'h00, 0, 1'b0, 0, 8'h00, 1'b1);
			else if (sum_prior != b)
				owe_result(ST_BAD_SUM, 8'h00, 0, 1'b0, 0, 8'h00, 1'b1);
			else if (cmd != ACK_COMMAND) begin
				if (frame_len == 0)
					owe_result(ST_OK, cmd, 0, 1'b0, 0, 8'h00, 1'b1);
				else
					for (i = 0; i < frame_len; i++)
						owe_result(ST_OK, cmd, frame_len, 1'b1, i,
							frame_bytes[PAYLOAD_OFFSET + i], i + 1 == frame_len);
			end
			restart_frame();
		end else if (byte_count >= BUFFER_BYTES) begin
			restart_frame();
			owe_result(ST_OVERFLOW, 8'h00, 0, 1'b0, 0, 8'h00, 1'b1);
		end
	endtask

	function automatic bit field_ok(string fname, int want, int got);
		if (want != got)
			$display("%0t: %s expected %0d, actual %0d", $time, fname, want, got);
		return want == got;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		frame_result_t want;
		if (!arst_n) begin
			results_due.delete();
			restart_frame();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual status %0d command %0d",
						$time, status, command);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					// bitwise and so every bad field gets reported
					if (!(field_ok("status", int'(want.status), int'(status))
						& field_ok("command", int'(want.command), int'(command))
						& field_ok("payload_len", int'(want.plen), int'(payload_len))
						& field_ok("has_payload", int'(want.has_p), int'(has_payload))
						& field_ok("payload_index", int'(want.idx), int'(payload_index))
						& field_ok("payload_byte", int'(want.data), int'(payload_byte))
						& field_ok("last", int'(want.last), int'(last))))
						mismatches++;
				end
			end
			if (in_valid && !in_stall)
				deframe_byte(rx_byte);
			pending = results_due.size();
		end
	end

endmodule

// ===== sim/serial_frame_receiver_top_tb.sv =====
`timescale 1ns / 100ps

module serial_frame_receiver_top_tb;
	import sfr_pkg::*;

	localparam int BUFFER_BYTES = 64;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 200;

	typedef enum {SUM_GOOD, SUM_BAD, SUM_NONE} sum_kind_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [1:0] status;
	logic [7:0] command;
	logic [5:0] payload_len;
	logic       has_payload;
	logic [5:0] payload_index;
	logic [7:0] payload_byte;
	logic       last;

	int mismatches;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_sent    = 0;
	int quiet_cycles  = 0;
	int hold_left     = 0;
	bit hold_req      = 1'b0;
	bit hold_taken    = 1'b0;

	always #6 clk = ~clk;

	serial_frame_receiver_top #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .command(command), .payload_len(payload_len),
		.has_payload(has_payload), .payload_index(payload_index),
		.payload_byte(payload_byte), .last(last)
	);

	serial_frame_receiver_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .command(command), .payload_len(payload_len),
		.has_payload(has_payload), .payload_index(payload_index),
		.payload_byte(payload_byte), .last(last),
		.mismatches(mismatches), .pending(pending)
	);

	// output side: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			out_stall  <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("[serial_frame_receiver_top] ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] hdr, input logic [15:0] len_field,
			input logic [7:0] cmd, input int body_len, input sum_kind_t sum_kind);
		logic [7:0] sum;
		logic [7:0] b;
		int         i;
		sum = hdr + len_field[15:8] + len_field[7:0] + cmd;
		send_byte(hdr);
		send_byte(len_field[15:8]);
		send_byte(len_field[7:0]);
		send_byte(cmd);
		for (i = 0; i < body_len; i++) begin
			b   = 8'($urandom_range(255));
			sum = sum + b;
			send_byte(b);
		end
		if (sum_kind == SUM_GOOD)
			send_byte(sum);
		else if (sum_kind == SUM_BAD) begin
			b = 8'($urandom_range(255, 1));
			send_byte(sum + b);
		end
	endtask

	task automatic pause_until_drained;
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// mostly well-formed frames with small payloads, some errors and noise
	task automatic random_frames(input int count);
		int         stop_at;
		int         pick;
		int         plen;
		logic [7:0] hdr;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			plen = ($urandom_range(9) == 0) ? $urandom_range(59, 9) : $urandom_range(8);
			if (pick < 8) begin
				do
					hdr = 8'($urandom_range(255));
				while (hdr == HEADER_BYTE);
				send_frame(hdr, 16'(plen), 8'($urandom_range(255)), plen,
					$urandom_range(1) ? SUM_GOOD : SUM_BAD);
			end else if (pick < 16)
				send_frame(HEADER_BYTE, 16'(plen), 8'($urandom_range(255)), plen, SUM_BAD);
			else if (pick < 24)
				send_frame(HEADER_BYTE, 16'(plen), ACK_COMMAND, plen, SUM_GOOD);
			else if (pick < 27)
				send_frame(HEADER_BYTE, 16'($urandom_range(65535, 60)),
					8'($urandom_range(255)), BUFFER_BYTES - PAYLOAD_OFFSET, SUM_NONE);
			else if (pick < 31)
				repeat ($urandom_range(4, 1))
					send_byte(8'($urandom_range(255)));
			else
				send_frame(HEADER_BYTE, 16'(plen), 8'($urandom_range(255)), plen, SUM_GOOD);
		end
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 12;
		recv_idle_pct <= 80;
		send_frame(HEADER_BYTE, 16'd0, 8'hFF, 0, SUM_GOOD);
		send_frame(HEADER_BYTE, 16'd1, 8'hA5, 1, SUM_GOOD);
		// completing byte lands on the last buffer slot
		send_frame(HEADER_BYTE, 16'd59, 8'h01, 59, SUM_GOOD);
		send_frame(HEADER_BYTE, 16'd3, ACK_COMMAND, 3, SUM_GOOD);
		send_frame(HEADER_BYTE, 16'd0, ACK_COMMAND, 0, SUM_GOOD);
		send_frame(8'h00, 16'd2, 8'h80, 2, SUM_GOOD);
		send_frame(8'hFD, 16'd1, 8'h7F, 1, SUM_BAD);
		send_frame(HEADER_BYTE, 16'd1, 8'h42, 1, SUM_BAD);
		send_frame(HEADER_BYTE, 16'hFFFF, 8'h10, BUFFER_BYTES - PAYLOAD_OFFSET, SUM_NONE);
		send_frame(HEADER_BYTE, 16'd60, 8'h11, BUFFER_BYTES - PAYLOAD_OFFSET, SUM_NONE);
		pause_until_drained();

		random_frames(40);
		pause_until_drained();

		send_idle_pct = 80;
		recv_idle_pct <= 12;
		random_frames(40);
		pause_until_drained();

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		// output held off long enough for the input to back up
		hold_req <= 1'b1;
		send_frame(HEADER_BYTE, 16'd40, 8'h5A, 40, SUM_GOOD);
		send_frame(HEADER_BYTE, 16'd6, 8'h33, 6, SUM_GOOD);
		send_frame(HEADER_BYTE, 16'd2, 8'hC3, 2, SUM_BAD);
		random_frames(30);
		pause_until_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[serial_frame_receiver_top] OK");
		else
			$display("[serial_frame_receiver_top] ERROR");
		$finish;
	end

endmodule
